// ----- rtl/url_percent_decoder_top_assert.svh -----
// assertion macros for the url percent decoder
`ifndef URL_PERCENT_DECODER_TOP_ASSERT_SVH
`define URL_PERCENT_DECODER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define UPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/upd_pkg.sv -----
// shared constants and character helpers for the url percent decoder
`default_nettype none

package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_W       = 8'h57;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // register indexes on the configuration port
    localparam logic REG_PLUS_AS_SPACE = 1'b0;
    localparam logic REG_OUT_LIMIT     = 1'b1;

    function automatic logic is_hex(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | CASE_BIT;
        return ((c >= CH_ZERO) && (c <= CH_NINE)) || ((lc >= CH_LOW_A) && (lc <= CH_LOW_F));
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] lc;
        logic [7:0] diff;
        lc = c | CASE_BIT;
        if ((c >= CH_ZERO) && (c <= CH_NINE))
        begin
            diff = c - CH_ZERO;
        end
        else
        begin
            diff = lc - CH_W;
        end
        return diff[3:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/upd_in_if.sv -----
// encoded byte channel: one raw byte and its end-of-string flag per word
`default_nettype none

interface upd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/upd_out_if.sv -----
// decoded result channel: one decoded byte or end marker per word
`default_nettype none

interface upd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        run_last;
    logic        string_end;
    logic [15:0] out_length;
    logic        truncated;

    modport source (output valid, output out_byte, output has_byte, output run_last,
                    output string_end, output out_length, output truncated, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input run_last,
                    input string_end, input out_length, input truncated, output ready);
endinterface

`default_nettype wire

// ----- rtl/url_percent_decoder_top.sv -----
// url percent decoder: escape state, output limit and result group buffer
//
//  channel  | dir  | word contents
//  ---------+------+------------------------------------------------------------
//  enc      | sink | in_byte, in_last
//  dec      | src  | out_byte, has_byte, run_last, string_end, out_length, truncated
//  cfg      | in   | cfg_we, cfg_index, cfg_data (plus_as_space, out_limit)
//
// one input word is decoded in the cycle it is accepted and yields 0 to 3 result words
// a group of results drains from the group buffer one word per cycle while dec.ready
// is high, so an input word that gives one result sustains one word per cycle; a malformed
// escape that gives two or three results holds enc.ready low until its last word is being taken
// enc.ready is high while the buffer is empty or its last word is being taken
// reset restores plus_as_space = 1, out_limit = 2048 and an idle escape state
`default_nettype none

`include "url_percent_decoder_top_assert.svh"

module url_percent_decoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    upd_in_if.sink           enc,
    upd_out_if.source        dec,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    // escape phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    // configuration
    logic        plus_reg;
    logic [15:0] limit_reg;

    // per-string decode state
    logic [1:0]  phase_reg;
    logic [7:0]  held_reg;
    logic [15:0] produced_reg;
    logic        dropped_reg;

    // result group buffer; slot 0 is the word on offer
    logic [7:0]  slot_byte_reg [3];
    logic [2:0]  slot_has_reg;
    logic [1:0]  cnt_reg;
    logic [15:0] len_reg;
    logic        trunc_reg;
    logic        last_reg;

    logic        acc;
    logic        take;

    // decode of the incoming byte
    logic [7:0]  b;
    logic        last;
    logic        b_hex;
    logic        idle_emit;
    logic [7:0]  idle_byte;
    logic        idle_esc;
    logic [7:0]  cand [3];
    logic [1:0]  n_cand;
    logic [1:0]  phase_next;
    logic [7:0]  held_next;

    // limit handling
    logic [15:0] cap;
    logic [15:0] room_wide;
    logic [1:0]  room;
    logic [1:0]  n_emit;
    logic        drop;
    logic [15:0] produced_next;
    logic        dropped_next;
    logic [1:0]  res_cnt;

    assign b    = enc.in_byte;
    assign last = enc.in_last;

    assign take      = dec.valid & dec.ready;
    assign enc.ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && dec.ready);
    assign acc       = enc.valid & enc.ready;

    assign b_hex = upd_pkg::is_hex(b);

    // byte handling outside an escape
    always_comb
    begin
        idle_esc  = (b == upd_pkg::CH_PERCENT) && !last;
        idle_emit = !idle_esc;
        if (plus_reg && (b == upd_pkg::CH_PLUS))
        begin
            idle_byte = upd_pkg::CH_SPACE;
        end
        else
        begin
            idle_byte = b;
        end
    end

    // candidate bytes in emission order, before the limit
    always_comb
    begin
        cand[0]    = 8'h00;
        cand[1]    = 8'h00;
        cand[2]    = 8'h00;
        n_cand     = 2'd0;
        phase_next = PH_IDLE;
        held_next  = held_reg;
        unique case (phase_reg)
            PH_PCT:
            begin
                if (b_hex && !last)
                begin
                    held_next  = b;
                    phase_next = PH_DIGIT;
                end
                else
                begin
                    // lone percent goes out literally, then the byte afresh
                    cand[0]    = upd_pkg::CH_PERCENT;
                    cand[1]    = idle_byte;
                    n_cand     = {1'b0, idle_emit} + 2'd1;
                    phase_next = idle_esc ? PH_PCT : PH_IDLE;
                end
            end
            PH_DIGIT:
            begin
                if (b_hex)
                begin
                    cand[0] = {upd_pkg::hex_value(held_reg), upd_pkg::hex_value(b)};
                    n_cand  = 2'd1;
                end
                else
                begin
                    // percent and held digit literally, then the byte afresh
                    cand[0]    = upd_pkg::CH_PERCENT;
                    cand[1]    = held_reg;
                    cand[2]    = idle_byte;
                    n_cand     = {1'b0, idle_emit} + 2'd2;
                    phase_next = idle_esc ? PH_PCT : PH_IDLE;
                end
            end
            default:
            begin
                cand[0]    = idle_byte;
                n_cand     = {1'b0, idle_emit};
                phase_next = idle_esc ? PH_PCT : PH_IDLE;
            end
        endcase
    end

    // bytes that still fit under out_limit - 1
    always_comb
    begin
        cap       = (limit_reg == 16'd0) ? 16'd0 : (limit_reg - 16'd1);
        room_wide = (cap > produced_reg) ? (cap - produced_reg) : 16'd0;
        room      = (room_wide >= 16'd3) ? 2'd3 : room_wide[1:0];
        n_emit    = (n_cand < room) ? n_cand : room;
        drop      = n_cand > room;
        produced_next = produced_reg + {14'd0, n_emit};
        dropped_next  = dropped_reg | drop;
        // a last word with nothing to show still gives a bare end marker
        res_cnt   = ((n_emit == 2'd0) && last) ? 2'd1 : n_emit;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plus_reg  <= 1'b1;
            limit_reg <= 16'd2048;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                upd_pkg::REG_PLUS_AS_SPACE: plus_reg  <= cfg_data[0];
                upd_pkg::REG_OUT_LIMIT:     limit_reg <= cfg_data;
                default:                    limit_reg <= limit_reg;
            endcase
        end
    end

    // decode state, cleared at the end of each string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            held_reg     <= 8'h00;
            produced_reg <= 16'd0;
            dropped_reg  <= 1'b0;
        end
        else if (acc)
        begin
            if (last)
            begin
                phase_reg    <= PH_IDLE;
                held_reg     <= 8'h00;
                produced_reg <= 16'd0;
                dropped_reg  <= 1'b0;
            end
            else
            begin
                phase_reg    <= phase_next;
                held_reg     <= held_next;
                produced_reg <= produced_next;
                dropped_reg  <= dropped_next;
            end
        end
    end

    // group control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (acc)
        begin
            cnt_reg <= res_cnt;
        end
        else if (take)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // group payload: load on accept, shift toward slot 0 as words leave
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            for (int k = 0; k < 3; k++)
            begin
                slot_byte_reg[k] <= (k < n_emit) ? cand[k] : 8'h00;
                slot_has_reg[k]  <= k < n_emit;
            end
            len_reg   <= produced_next;
            trunc_reg <= dropped_next;
            last_reg  <= last;
        end
        else if (take)
        begin
            slot_byte_reg[0] <= slot_byte_reg[1];
            slot_byte_reg[1] <= slot_byte_reg[2];
            slot_byte_reg[2] <= 8'h00;
            slot_has_reg     <= {1'b0, slot_has_reg[2:1]};
        end
    end

    assign dec.valid      = cnt_reg != 2'd0;
    assign dec.out_byte   = slot_byte_reg[0];
    assign dec.has_byte   = slot_has_reg[0];
    assign dec.run_last   = cnt_reg == 2'd1;
    assign dec.string_end = (cnt_reg == 2'd1) && last_reg;
    assign dec.out_length = len_reg;
    assign dec.truncated  = trunc_reg;

    // a new word is only taken once the previous group is drained or its last word is being taken
    `UPD_ASSERT_NOW(a_accept_drained, acc, (cnt_reg == 2'd0) || take, "accept over pending results")
    // end of string returns the decode state to idle
    `UPD_ASSERT_NEXT(a_last_clears, acc && last, (phase_reg == PH_IDLE) && (produced_reg == 16'd0) && !dropped_reg, "string state not cleared")
    // the unused phase code never appears
    `UPD_ASSERT_NOW(a_phase_legal, 1'b1, phase_reg != 2'd3, "illegal escape phase")
    // a bare end marker only closes a string
    `UPD_ASSERT_NOW(a_marker_end, dec.valid && !dec.has_byte, dec.string_end, "bare marker inside a string")

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// testbench for the url percent decoder: byte streams checked by a scoreboard under flow control
module testbench;

    // receiver hold-off long enough to back the block up into its input
    localparam int HOLD_CYCLES     = 80;
    // cycles with no word moving on either channel before the run is called hung
    localparam int STALL_LIMIT     = 1000;
    // encoded words per random phase, rounded up to whole strings
    localparam int WORDS_PER_PHASE = 12;
    // quiet cycles before a register write and at the very end
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 8;

    typedef enum logic [1:0] {ESC_IDLE, ESC_PERCENT, ESC_DIGIT} esc_phase_t;

    // one decoded word as it leaves the block
    typedef struct {
        logic [7:0]  out_byte;
        logic        has_byte;
        logic        run_last;
        logic        string_end;
        logic [15:0] out_length;
        logic        truncated;
    } dec_word_t;

    // decoder prediction and the queue of decoded words still owed by the block
    class url_decode_board;
        bit          plus_mode = 1'b1;
        logic [15:0] limit     = 16'd2048;
        esc_phase_t  phase     = ESC_IDLE;
        logic [7:0]  held      = 8'h00;
        logic [15:0] produced  = 16'h0000;
        bit          dropped   = 1'b0;
        logic [7:0]  emitted[$];
        dec_word_t   expected_words[$];
        int          mismatches = 0;

        // digit check and value in one go: upper and lower case letters both count
        function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
            logic [7:0] d;
            d = 8'h00;
            v = 4'h0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                d = c - upd_pkg::CH_ZERO;
                v = d[3:0];
                return 1'b1;
            end
            if (c >= 8'h61 && c <= 8'h66)
            begin
                d = c - upd_pkg::CH_W;
                v = d[3:0];
                return 1'b1;
            end
            if (c >= 8'h41 && c <= 8'h46)
            begin
                d = c - 8'h37;
                v = d[3:0];
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // a byte either fits under the limit or is dropped and marks the string
        function void emit(input logic [7:0] b);
            logic [15:0] cap;
            cap = (limit == 16'd0) ? 16'd0 : limit - 16'd1;
            if (produced < cap)
            begin
                emitted.push_back(b);
                produced = produced + 16'd1;
            end
            else
            begin
                dropped = 1'b1;
            end
        endfunction

        function void plain_byte(input logic [7:0] b, input bit last);
            if (b == upd_pkg::CH_PERCENT && !last)
                phase = ESC_PERCENT;
            else if (plus_mode && b == upd_pkg::CH_PLUS)
                emit(upd_pkg::CH_SPACE);
            else
                emit(b);
        endfunction

        function void note_encoded(input logic [7:0] b, input bit last);
            logic [3:0] hi;
            logic [3:0] lo;
            int         n;
            dec_word_t  w;
            emitted.delete();
            case (phase)
                ESC_PERCENT:
                begin
                    if (hex_nibble(b, lo) && !last)
                    begin
                        held  = b;
                        phase = ESC_DIGIT;
                    end
                    else
                    begin
                        emit(upd_pkg::CH_PERCENT);
                        phase = ESC_IDLE;
                        plain_byte(b, last);
                    end
                end
                ESC_DIGIT:
                begin
                    if (hex_nibble(b, lo))
                    begin
                        void'(hex_nibble(held, hi));
                        emit({hi, lo});
                        phase = ESC_IDLE;
                    end
                    else
                    begin
                        emit(upd_pkg::CH_PERCENT);
                        emit(held);
                        phase = ESC_IDLE;
                        plain_byte(b, last);
                    end
                end
                default:
                begin
                    phase = ESC_IDLE;
                    plain_byte(b, last);
                end
            endcase
            n = emitted.size();
            if (last && n == 0)
                n = 1;
            for (int k = 0; k < n; k++)
            begin
                w.has_byte   = (k < emitted.size());
                w.out_byte   = w.has_byte ? emitted[k] : 8'h00;
                w.run_last   = (k == n - 1);
                w.string_end = (k == n - 1) && last;
                w.out_length = produced;
                w.truncated  = dropped;
                expected_words.push_back(w);
            end
            if (last)
            begin
                phase    = ESC_IDLE;
                held     = 8'h00;
                produced = 16'h0000;
                dropped  = 1'b0;
            end
        endfunction

        task report(input string msg);
            $display("%0t mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_decoded(input dec_word_t got);
            dec_word_t want;
            if (expected_words.size() == 0)
            begin
                report($sformatf("unexpected word, byte %02h", got.out_byte));
                return;
            end
            want = expected_words.pop_front();
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
            if (got.has_byte !== want.has_byte)
                report($sformatf("has_byte %b, want %b", got.has_byte, want.has_byte));
            if (got.run_last !== want.run_last)
                report($sformatf("run_last %b, want %b", got.run_last, want.run_last));
            if (got.string_end !== want.string_end)
                report($sformatf("string_end %b, want %b", got.string_end, want.string_end));
            if (got.out_length !== want.out_length)
                report($sformatf("out_length %0d, want %0d", got.out_length, want.out_length));
            if (got.truncated !== want.truncated)
                report($sformatf("truncated %b, want %b", got.truncated, want.truncated));
        endtask

        function int waiting();
            return expected_words.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data  = 16'h0000;

    // steady turns off random idling on both sides; hold_req asks for a long receiver hold-off
    bit steady   = 1'b0;
    bit hold_req = 1'b0;

    // register settings for the random phases: limit extremes, two small ones and the reset value
    bit          plus_plan[5]  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic [15:0] limit_plan[5] = '{16'hFFFF, 16'd1, 16'd6, 16'd2048, 16'd12};

    url_decode_board board = new();

    upd_in_if  enc_ch();
    upd_out_if dec_ch();

    url_percent_decoder_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc       (enc_ch),
        .dec       (dec_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // send one string, last flag on its final byte; prediction updated as each word is taken
    task automatic send_string(input logic [7:0] chars[$]);
        int i;
        bit is_last;
        for (i = 0; i < chars.size(); i++)
        begin
            is_last = (i == chars.size() - 1);
            // random gaps drop valid between words, never inside a handshake
            while (!steady && $urandom_range(99) < 17)
            begin
                enc_ch.valid <= 1'b0;
                @(posedge clk);
            end
            enc_ch.valid   <= 1'b1;
            enc_ch.in_byte <= chars[i];
            enc_ch.in_last <= is_last;
            do
                @(posedge clk);
            while (!enc_ch.ready);
            board.note_encoded(chars[i], is_last);
        end
    endtask

    task automatic send_text(input string s);
        logic [7:0] chars[$];
        for (int i = 0; i < s.len(); i++)
            chars.push_back(s[i]);
        send_string(chars);
    endtask

    // stop offering words and wait for every owed decoded word, then let the block settle
    task automatic wait_drained();
        enc_ch.valid <= 1'b0;
        while (board.waiting() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write per clock; we stays high across back-to-back writes
    task automatic write_reg(input logic idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic set_config(input bit plus, input logic [15:0] lim);
        write_reg(upd_pkg::REG_PLUS_AS_SPACE, {15'd0, plus});
        board.plus_mode = plus;
        write_reg(upd_pkg::REG_OUT_LIMIT, lim);
        board.limit = lim;
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char();
        logic [3:0] v;
        v = 4'($urandom_range(15));
        if (v < 4'd10)
            return upd_pkg::CH_ZERO + 8'(v);
        return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic [3:0] v;
        do
            c = 8'($urandom_range(255));
        while (board.hex_nibble(c, v));
        return c;
    endfunction

    // a string of a few tokens: mostly good escapes and plain bytes, some broken or cut escapes
    function automatic void random_string(output logic [7:0] chars[$]);
        int tokens;
        int r;
        tokens = $urandom_range(6, 1);
        for (int t = 0; t < tokens; t++)
        begin
            r = $urandom_range(99);
            if (r < 35)
                chars.push_back(8'($urandom_range(255)));
            else if (r < 50)
                chars.push_back(upd_pkg::CH_PLUS);
            else
            begin
                chars.push_back(upd_pkg::CH_PERCENT);
                if (r < 75)
                begin
                    chars.push_back(hex_char());
                    chars.push_back(hex_char());
                end
                else if (r < 85)
                begin
                    chars.push_back(hex_char());
                    chars.push_back(non_hex_char());
                end
                else if (r < 95)
                begin
                    chars.push_back(non_hex_char());
                end
                // otherwise a lone percent, cut off if it lands at the end
            end
        end
    endfunction

    // receiver: checks each taken word, then picks ready for the next edge
    initial
    begin
        dec_word_t got;
        int        hold_left;
        hold_left    = 0;
        dec_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (dec_ch.valid && dec_ch.ready)
            begin
                got.out_byte   = dec_ch.out_byte;
                got.has_byte   = dec_ch.has_byte;
                got.run_last   = dec_ch.run_last;
                got.string_end = dec_ch.string_end;
                got.out_length = dec_ch.out_length;
                got.truncated  = dec_ch.truncated;
                board.check_decoded(got);
            end
            // long hold-off counted here so the sender keeps pushing until the block backs up
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                dec_ch.ready <= 1'b0;
            end
            else
            begin
                dec_ch.ready <= steady || ($urandom_range(99) >= 17);
            end
        end
    end

    // watchdog: any word moving on either side restarts the count
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (enc_ch.valid && enc_ch.ready) || (dec_ch.valid && dec_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] chars[$];
        int         words;
        int         ph;
        enc_ch.valid   = 1'b0;
        enc_ch.in_byte = 8'h00;
        enc_ch.in_last = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: form mode, limit 2048
        send_text("%4A");       // upper case escape
        send_text("%fe+");      // lower case escape, plus turns into space
        send_text("%4G");       // bad second digit: three words from one input word
        send_text("%%");        // lone percent goes out literally, then a percent cut by the end
        send_text("%5");        // hex digit on the last word does not start an escape
        send_text("%");         // lone percent as a whole string
        send_text("%5z");       // held digit flushed by a non-hex last word
        chars.push_back(8'h00);
        chars.push_back(8'hFF);
        send_string(chars);     // byte extremes pass through untouched

        // plus kept literal, room for two bytes: the rest drops and the end comes back bare
        wait_drained();
        set_config(1'b0, 16'd3);
        send_text("a+%41b");

        // zero limit acts as one: nothing is ever produced
        wait_drained();
        set_config(1'b1, 16'd0);
        send_text("x");

        // random strings across the setting plan; phase 0 runs with no idling,
        // phase 2 starts with the receiver held off
        for (ph = 0; ph < 5; ph++)
        begin
            wait_drained();
            set_config(plus_plan[ph], limit_plan[ph]);
            steady = (ph == 0);
            if (ph == 2)
                hold_req = 1'b1;
            words = 0;
            while (words < WORDS_PER_PHASE)
            begin
                random_string(chars);
                send_string(chars);
                words += chars.size();
            end
        end
        steady = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/upd_pkg.sv
rtl/upd_in_if.sv
rtl/upd_out_if.sv
rtl/url_percent_decoder_top.sv
sim/testbench.sv
